### rtl/dns_name_decompressor_top_macros.svh
// Assertion macros used by the DNS name decompressor walker.
`ifndef DNS_NAME_DECOMPRESSOR_TOP_MACROS_SVH
`define DNS_NAME_DECOMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define DNSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define DNSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dnsd_pkg.sv
// Shared constants, codes and types of the DNS name decompressor.
`default_nettype none
package dnsd_pkg;

  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned MAX_NAME    = 255;
  localparam int unsigned MAX_HOPS    = 5;

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned HOP_W  = $clog2(MAX_HOPS + 2);
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned OFF_W  = 14;
  localparam int unsigned IN_ADDR_W = 9;

  localparam logic [7:0] OFFSET_MASK = 8'h3f;
  localparam logic [7:0] DOT_CHAR    = 8'h2e;

  localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO      = CNT_W'(2);
  localparam logic [CNT_W-1:0] NAME_LIMIT   = CNT_W'(MAX_NAME);
  localparam logic [CNT_W-1:0] NAME_CAP     = CNT_W'(MAX_NAME + 1);
  localparam logic [HOP_W-1:0] HOP_ONE      = HOP_W'(1);
  localparam logic [HOP_W-1:0] HOP_LIMIT    = HOP_W'(MAX_HOPS);
  localparam logic [HOP_W-1:0] HOP_CAP      = HOP_W'(MAX_HOPS + 1);
  localparam logic [OFF_W-1:0] STORE_END    = OFF_W'(STORE_DEPTH);

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Top two bits of a length byte
  localparam logic [1:0] TAG_LABEL = 2'b00;
  localparam logic [1:0] TAG_PTR   = 2'b11;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TAG   = 3'd1;
  localparam logic [2:0] ST_HOPS      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_PTR_RANGE = 3'd4;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [31:0]      chars;
    logic [2:0]       char_count;
    logic             last;
    logic [2:0]       status;
    logic [CNT_W-1:0] consumed;
  } result_t;

endpackage
`default_nettype wire

### rtl/dns_name_decompressor_top.sv
// Top level of the DNS name decompressor.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_ready_o | command, address, data, byte_budget
//   out     | output    | out_valid_o/out_ready_i | chars, char_count, last, status, consumed
//
// A load writes one store byte. A decode reads its start byte, then steps through each length or
// end byte, each name character, each dot, both bytes of each pointer and the final
// word in turn; the single read port of the byte store sets this pace.
// The walker waits whenever a word is due and the output register is still full.
// Reset clears the control state; the byte store holds garbage until written.
// The input is not ready while a decode walks.
`default_nettype none
module dns_name_decompressor_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic [dnsd_pkg::IN_ADDR_W-1:0] address_i,
  input  wire logic [7:0]                     data_i,
  input  wire logic [dnsd_pkg::CNT_W-1:0]     byte_budget_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [31:0]                         chars_o,
  output logic [2:0]                          char_count_o,
  output logic                                last_o,
  output logic [2:0]                          status_o,
  output logic [dnsd_pkg::CNT_W-1:0]          consumed_o
);

  dnsd_pkg::mem_req_t mem_req;
  logic [7:0]         rdata;
  logic               out_free;
  logic               push_valid;
  dnsd_pkg::result_t  push;
  dnsd_pkg::result_t  result;

  dnsd_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  dnsd_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .byte_budget_i (byte_budget_i),
    .mem_req_o     (mem_req),
    .rdata_i       (rdata),
    .out_free_i    (out_free),
    .push_valid_o  (push_valid),
    .push_o        (push)
  );

  dnsd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push),
    .out_free_o   (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign chars_o      = result.chars;
  assign char_count_o = result.char_count;
  assign last_o       = result.last;
  assign status_o     = result.status;
  assign consumed_o   = result.consumed;

endmodule
`default_nettype wire

### rtl/dnsd_store.sv
// Packet byte store: one write port, one registered read port.
`default_nettype none
module dnsd_store (
  input  wire logic               clk_i,
  input  wire dnsd_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);

  logic [7:0] mem_q [dnsd_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Hold the read word when no read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/dnsd_walker.sv
// Label walker: sequencer that reads the store one byte at a time and packs characters.
`default_nettype none
`include "dns_name_decompressor_top_macros.svh"
module dnsd_walker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                command_i,
  input  wire logic [dnsd_pkg::IN_ADDR_W-1:0]      address_i,
  input  wire logic [7:0]                          data_i,
  input  wire logic [dnsd_pkg::CNT_W-1:0]          byte_budget_i,
  output dnsd_pkg::mem_req_t                       mem_req_o,
  input  wire logic [7:0]                          rdata_i,
  input  wire logic                                out_free_i,
  output logic                                     push_valid_o,
  output dnsd_pkg::result_t                        push_o
);

  localparam int unsigned AW = dnsd_pkg::ADDR_W;
  localparam int unsigned CW = dnsd_pkg::CNT_W;
  localparam int unsigned HW = dnsd_pkg::HOP_W;
  localparam int unsigned OW = dnsd_pkg::OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_PTR  = 3'd2;
  localparam logic [2:0] S_CHR  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] nc_q, nc_d;
  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] limit_q, limit_d;
  logic [HW-1:0] hop_q, hop_d;
  logic          at_top_q, at_top_d;
  logic          dot_q, dot_d;
  logic [5:0]    rem_q, rem_d;
  logic [5:0]    ptr_hi_q, ptr_hi_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   chunk_q, chunk_d;
  logic [1:0]    fill_q, fill_d;

  logic          emit_en;
  logic [7:0]    emit_char;
  logic          emit_blocked;
  logic [5:0]    masked;
  logic [CW-1:0] nc_new;
  logic [OW-1:0] off;
  logic [AW-1:0] pos_inc;
  logic          chr_stall;

  assign masked       = 6'(rdata_i & dnsd_pkg::OFFSET_MASK);
  assign nc_new       = nc_q + CW'(masked) + dnsd_pkg::CNT_ONE;
  assign off          = {ptr_hi_q, rdata_i};
  assign pos_inc      = pos_q + AW'(1);
  // A character that completes a word needs a free output slot.
  assign emit_blocked = (fill_q == 2'd3) && !out_free_i;
  assign in_ready_o   = (state_q == S_IDLE);
  assign chr_stall    = (state_q == S_CHR) && emit_blocked;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    nc_d         = nc_q;
    top_d        = top_q;
    limit_d      = limit_q;
    hop_d        = hop_q;
    at_top_d     = at_top_q;
    dot_d        = dot_q;
    rem_d        = rem_q;
    ptr_hi_d     = ptr_hi_q;
    status_d     = status_q;
    chunk_d      = chunk_q;
    fill_d       = fill_q;
    emit_en      = 1'b0;
    emit_char    = rdata_i;
    mem_req_o    = '0;
    push_valid_o = 1'b0;
    push_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == dnsd_pkg::CMD_LOAD) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = AW'(address_i);
            mem_req_o.wdata = data_i;
          end else begin
            pos_d           = AW'(address_i);
            nc_d            = '0;
            top_d           = '0;
            hop_d           = '0;
            at_top_d        = 1'b1;
            dot_d           = 1'b0;
            status_d        = dnsd_pkg::ST_OK;
            limit_d         = byte_budget_i;
            chunk_d         = '0;
            fill_d          = '0;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = AW'(address_i);
            state_d         = S_LEN;
          end
        end
      end

      S_LEN: begin
        if (dot_q && (rdata_i != 8'd0)) begin
          // Emit the dot first; the length byte stays in the read register.
          if (!emit_blocked) begin
            emit_en   = 1'b1;
            emit_char = dnsd_pkg::DOT_CHAR;
            dot_d     = 1'b0;
          end
        end else begin
          dot_d = 1'b0;
          if (rdata_i == 8'd0) begin
            nc_d = nc_q + dnsd_pkg::CNT_ONE;
            if (at_top_q) begin
              top_d = nc_q + dnsd_pkg::CNT_ONE;
            end
            state_d = S_FIN;
          end else if (rdata_i[7:6] == dnsd_pkg::TAG_PTR) begin
            if (hop_q > dnsd_pkg::HOP_LIMIT) begin
              status_d = dnsd_pkg::ST_HOPS;
              state_d  = S_FIN;
            end else begin
              ptr_hi_d        = masked;
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = pos_inc;
              state_d         = S_PTR;
            end
          end else if (rdata_i[7:6] != dnsd_pkg::TAG_LABEL) begin
            status_d = dnsd_pkg::ST_BAD_TAG;
            state_d  = S_FIN;
          end else if ((nc_new > dnsd_pkg::NAME_LIMIT) || (nc_new > limit_q)) begin
            status_d = dnsd_pkg::ST_TOO_LONG;
            state_d  = S_FIN;
          end else begin
            nc_d            = nc_new;
            rem_d           = masked;
            pos_d           = pos_inc;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = pos_inc;
            state_d         = S_CHR;
          end
        end
      end

      S_PTR: begin
        if (off >= dnsd_pkg::STORE_END) begin
          status_d = dnsd_pkg::ST_PTR_RANGE;
          state_d  = S_FIN;
        end else begin
          if (at_top_q) begin
            top_d    = nc_q + dnsd_pkg::CNT_TWO;
            at_top_d = 1'b0;
          end
          hop_d           = hop_q + dnsd_pkg::HOP_ONE;
          pos_d           = AW'(off);
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AW'(off);
          state_d         = S_LEN;
        end
      end

      S_CHR: begin
        if (!emit_blocked) begin
          emit_en         = 1'b1;
          pos_d           = pos_inc;
          rem_d           = rem_q - 6'd1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = pos_inc;
          // After the last character the next read is the following length byte.
          if (rem_q == 6'd1) begin
            dot_d   = 1'b1;
            state_d = S_LEN;
          end
        end
      end

      S_FIN: begin
        if (out_free_i) begin
          push_valid_o      = 1'b1;
          push_o.chars      = chunk_q;
          push_o.char_count = {1'b0, fill_q};
          push_o.last       = 1'b1;
          push_o.status     = status_q;
          push_o.consumed   = (status_q == dnsd_pkg::ST_OK) ? top_q : '0;
          chunk_d           = '0;
          fill_d            = '0;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_en) begin
      if (fill_q == 2'd3) begin
        push_valid_o      = 1'b1;
        push_o.chars      = {emit_char, chunk_q[23:0]};
        push_o.char_count = 3'd4;
        chunk_d           = '0;
        fill_d            = '0;
      end else begin
        chunk_d[8*fill_q +: 8] = emit_char;
        fill_d                 = fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      nc_q     <= '0;
      top_q    <= '0;
      hop_q    <= '0;
      at_top_q <= 1'b0;
      dot_q    <= 1'b0;
      rem_q    <= '0;
      status_q <= dnsd_pkg::ST_OK;
      chunk_q  <= '0;
      fill_q   <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      nc_q     <= nc_d;
      top_q    <= top_d;
      hop_q    <= hop_d;
      at_top_q <= at_top_d;
      dot_q    <= dot_d;
      rem_q    <= rem_d;
      status_q <= status_d;
      chunk_q  <= chunk_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q  <= limit_d;
    ptr_hi_q <= ptr_hi_d;
  end

  `DNSD_ASSERT_NOW(a_push_has_slot, push_valid_o, out_free_i, "push without free slot")
  `DNSD_ASSERT_NEXT(a_last_ends, push_valid_o && push_o.last, state_q == S_IDLE, "walk not ended")
  `DNSD_ASSERT_NOW(a_hop_bound, state_q != S_IDLE, hop_q <= dnsd_pkg::HOP_CAP, "hop overrun")
  `DNSD_ASSERT_NOW(a_name_bound, state_q != S_IDLE, nc_q <= dnsd_pkg::NAME_CAP, "name overrun")
  `DNSD_ASSERT_NEXT(a_stall_holds, chr_stall, $stable(pos_q) && state_q == S_CHR, "stall not held")

endmodule
`default_nettype wire

### rtl/dnsd_out_reg.sv
// Output register: holds one result word until the consumer takes it.
`default_nettype none
module dnsd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  wire dnsd_pkg::result_t push_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dnsd_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  dnsd_pkg::result_t data_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      data_q <= push_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the DNS name decompressor: directed and random packets.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        command_i     = dnsd_pkg::CMD_LOAD;
  logic [8:0]  address_i     = '0;
  logic [7:0]  data_i        = '0;
  logic [9:0]  byte_budget_i = '0;
  logic        out_ready_i   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] chars_o;
  logic [2:0]  char_count_o;
  logic        last_o;
  logic [2:0]  status_o;
  logic [9:0]  consumed_o;

  // Mirror of the packet bytes sent so far
  logic [7:0] store_mirror [dnsd_pkg::STORE_DEPTH];
  bit         written      [dnsd_pkg::STORE_DEPTH];

  dnsd_pkg::result_t expected_words[$];
  dnsd_pkg::result_t name_words[$];
  logic [8:0]  name_starts[$];
  logic [31:0] word_buf;
  int          word_fill;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int sent_items   = 0;
  int word_total   = 0;
  int err_count    = 0;
  int quiet_cycles = 0;

  dns_name_decompressor_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .byte_budget_i (byte_budget_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chars_o       (chars_o),
    .char_count_o  (char_count_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .consumed_o    (consumed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void push_word(input logic fin, input logic [2:0] st,
                                    input logic [9:0] used);
    dnsd_pkg::result_t w;
    w.chars      = word_buf;
    w.char_count = 3'(word_fill);
    w.last       = fin;
    w.status     = st;
    w.consumed   = used;
    name_words.push_back(w);
    word_buf  = '0;
    word_fill = 0;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    word_buf[8*word_fill +: 8] = c;
    word_fill++;
    if (word_fill == 4) push_word(1'b0, dnsd_pkg::ST_OK, '0);
  endfunction

  // Predict the words of one decode into name_words. Return -1, or the first
  // address the walk would read before it was ever loaded.
  function automatic int walk_name(input logic [8:0] start, input logic [9:0] lim);
    logic [8:0]  pos;
    logic [8:0]  nxt;
    logic [7:0]  b;
    logic [13:0] off;
    logic [2:0]  st;
    int unsigned cnt;
    int unsigned top;
    int unsigned hops;
    bit          at_top;
    bit          done;
    name_words.delete();
    word_buf  = '0;
    word_fill = 0;
    pos    = start;
    cnt    = 0;
    top    = 0;
    hops   = 0;
    at_top = 1'b1;
    done   = 1'b0;
    st     = dnsd_pkg::ST_OK;
    while (!done) begin
      if (!written[pos]) return int'(pos);
      b   = store_mirror[pos];
      nxt = pos + 9'd1;
      if (b == 8'h00) begin
        cnt++;
        if (at_top) top = cnt;
        done = 1'b1;
      end else if (!written[nxt]) begin
        // the block may fetch the byte after any non-zero length byte
        return int'(nxt);
      end else if (b[7:6] == dnsd_pkg::TAG_PTR) begin
        off = 14'({b & dnsd_pkg::OFFSET_MASK, store_mirror[nxt]});
        if (hops > dnsd_pkg::MAX_HOPS) begin
          st   = dnsd_pkg::ST_HOPS;
          done = 1'b1;
        end else if (off >= dnsd_pkg::STORE_DEPTH) begin
          st   = dnsd_pkg::ST_PTR_RANGE;
          done = 1'b1;
        end else begin
          if (at_top) begin
            top    = cnt + 2;
            at_top = 1'b0;
          end
          hops++;
          pos = off[8:0];
        end
      end else if (b[7:6] != dnsd_pkg::TAG_LABEL) begin
        st   = dnsd_pkg::ST_BAD_TAG;
        done = 1'b1;
      end else begin
        cnt += b + 1;
        if (cnt > dnsd_pkg::MAX_NAME || cnt > lim) begin
          st   = dnsd_pkg::ST_TOO_LONG;
          done = 1'b1;
        end else begin
          pos = nxt;
          for (int i = 0; i < b; i++) begin
            if (!written[pos]) return int'(pos);
            add_char(store_mirror[pos]);
            pos++;
          end
          if (!written[pos]) return int'(pos);
          if (store_mirror[pos] != 8'h00) add_char(dnsd_pkg::DOT_CHAR);
        end
      end
    end
    push_word(1'b1, st, (st == dnsd_pkg::ST_OK) ? 10'(top) : 10'd0);
    return -1;
  endfunction

  // Hold valid across back-to-back items; drop it only for an idle gap.
  task automatic send_item(input logic cmd, input logic [8:0] addr,
                           input logic [7:0] dat, input logic [9:0] lim);
    if (cmd == dnsd_pkg::CMD_LOAD) begin
      store_mirror[addr] = dat;
      written[addr]      = 1'b1;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    address_i     <= addr;
    data_i        <= dat;
    byte_budget_i <= lim;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  task automatic load_byte(input logic [8:0] addr, input logic [7:0] dat);
    send_item(dnsd_pkg::CMD_LOAD, addr, dat, 10'($urandom_range(0, 512)));
  endtask

  // Fill any byte the walk would read unloaded, then issue the decode.
  task automatic send_decode(input logic [8:0] start, input logic [9:0] lim);
    int miss;
    miss = walk_name(start, lim);
    while (miss >= 0) begin
      load_byte(9'(miss), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      miss = walk_name(start, lim);
    end
    foreach (name_words[i]) expected_words.push_back(name_words[i]);
    word_total += name_words.size();
    send_item(dnsd_pkg::CMD_DECODE, start, 8'($urandom), lim);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic test_plain_labels();
    load_byte(9'd0, 8'd1);
    load_byte(9'd1, "a");
    load_byte(9'd2, 8'd2);
    load_byte(9'd3, "b");
    load_byte(9'd4, "c");
    load_byte(9'd5, 8'd0);
    load_byte(9'd10, 8'd0);
    send_decode(9'd0, 10'd512);
    send_decode(9'd10, 10'd512);
    // name length against the packet limit
    send_decode(9'd0, 10'd5);
    send_decode(9'd0, 10'd4);
    send_decode(9'd0, 10'd0);
  endtask

  task automatic test_pointers();
    load_byte(9'd20, 8'd1);
    load_byte(9'd21, "x");
    load_byte(9'd22, 8'hc0);
    load_byte(9'd23, 8'h00);
    load_byte(9'd511, 8'd0);
    load_byte(9'd24, 8'hc1);
    load_byte(9'd25, 8'hff);
    send_decode(9'd20, 10'd512);
    send_decode(9'd24, 10'd512);
  endtask

  task automatic test_pointer_errors();
    load_byte(9'd30, 8'h40);
    load_byte(9'd31, 8'h00);
    load_byte(9'd32, 8'hbf);
    load_byte(9'd33, 8'h00);
    load_byte(9'd40, 8'hc0);
    load_byte(9'd41, 8'd40);
    load_byte(9'd44, 8'hc2);
    load_byte(9'd45, 8'h00);
    load_byte(9'd46, 8'hff);
    load_byte(9'd47, 8'hff);
    send_decode(9'd30, 10'd512);
    send_decode(9'd32, 10'd512);
    send_decode(9'd40, 10'd512);
    send_decode(9'd44, 10'd512);
    send_decode(9'd46, 10'd512);
  endtask

  // A 50-byte label that points back to itself: five passes reach exactly the
  // maximum name length and the sixth is too long.
  task automatic test_name_length();
    load_byte(9'd100, 8'd50);
    for (int i = 101; i < 151; i++) load_byte(9'(i), 8'($urandom));
    load_byte(9'd151, 8'hc0);
    load_byte(9'd152, 8'd100);
    send_decode(9'd100, 10'd512);
    send_decode(9'd100, 10'd102);
    send_decode(9'd100, 10'd101);
  endtask

  task automatic test_random_traffic(input int in_idle, input int out_stall,
                                     input bit pause_mid);
    int         item_goal;
    int         word_goal;
    int         nlab;
    int         len;
    int         r;
    bit         paused;
    logic [8:0] base;
    logic [8:0] pos;
    logic [8:0] tgt;
    logic [9:0] lim;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    item_goal = sent_items + 5;
    word_goal = word_total + 3;
    paused    = 1'b0;
    while (sent_items < item_goal || word_total < word_goal) begin
      base = 9'($urandom_range(0, 511));
      pos  = base;
      nlab = $urandom_range(0, 2);
      for (int l = 0; l < nlab; l++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        load_byte(pos, 8'(len));
        pos++;
        for (int c = 0; c < len; c++) begin
          load_byte(pos, 8'($urandom));
          pos++;
        end
      end
      r = $urandom_range(0, 9);
      if (r <= 4) begin
        load_byte(pos, 8'h00);
      end else if (r <= 7) begin
        tgt = (name_starts.size() != 0) ?
              name_starts[$urandom_range(0, name_starts.size() - 1)] : base;
        load_byte(pos, {2'b11, 5'b0, tgt[8]});
        load_byte(pos + 9'd1, tgt[7:0]);
      end else if (r == 8) begin
        load_byte(pos, {2'($urandom_range(1, 2)), 6'($urandom)});
      end else begin
        load_byte(pos, {2'b11, 6'($urandom_range(2, 63))});
        load_byte(pos + 9'd1, 8'($urandom));
      end
      name_starts.push_back(base);
      for (int d = $urandom_range(1, 3); d > 0; d--) begin
        lim = ($urandom_range(0, 1) == 0) ? 10'd512 : 10'($urandom_range(0, 512));
        if ($urandom_range(0, 4) == 0) begin
          send_decode(9'($urandom), lim);
        end else begin
          send_decode(name_starts[$urandom_range(0, name_starts.size() - 1)], lim);
        end
      end
      if (pause_mid && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Compare each accepted word against the oldest prediction
  always @(posedge clk_i) begin : check_words
    dnsd_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("word with no prediction pending: chars %h last %b", chars_o, last_o);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (chars_o !== want.chars) begin
          $error("chars: expected %h, got %h", want.chars, chars_o);
          err_count++;
        end
        if (char_count_o !== want.char_count) begin
          $error("char_count: expected %0d, got %0d", want.char_count, char_count_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (consumed_o !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, consumed_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_labels();
    test_pointers();
    test_pointer_errors();
    test_name_length();
    test_random_traffic(47, 0, 1'b1);
    test_random_traffic(0, 47, 1'b0);
    test_random_traffic(29, 29, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/dnsd_pkg.sv
rtl/dnsd_store.sv
rtl/dnsd_walker.sv
rtl/dnsd_out_reg.sv
rtl/dns_name_decompressor_top.sv
tb/tb_top.sv
